[design/color_key_mirror_blit_writer_defines.svh]
// ----------------------------------------------------------------------------
// Color-key mirror blit writer: assertion macros
// Concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_MIRROR_BLIT_WRITER_DEFINES_SVH
`define COLOR_KEY_MIRROR_BLIT_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define CKMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset
`define CKMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CKMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CKMB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/ckmb_pkg.sv]
// ----------------------------------------------------------------------------
// Color-key mirror blit writer package
// Widths, register indexes, mode codes and clamp helpers.
// ----------------------------------------------------------------------------
package ckmb_pkg;

    localparam int ADDRESS_BITS   = 20;
    localparam int MAX_PITCH      = 1024;
    localparam int COLUMN_LIMIT   = 1024;
    localparam int PIXEL_BITS     = 8;
    localparam int COORD_BITS     = 10;
    localparam int SIZE_BITS      = 11;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;
    localparam int PROD_BITS      = ADDRESS_BITS + SIZE_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODE         = 3'd0,
        CFG_KEY_COLOR    = 3'd1,
        CFG_FILL_COLOR   = 3'd2,
        CFG_RECT_WIDTH   = 3'd3,
        CFG_DEST_X       = 3'd4,
        CFG_DEST_Y       = 3'd5,
        CFG_DEST_TOP_ROW = 3'd6,
        CFG_DEST_PITCH   = 3'd7
    } t_cfg_index;

    // Code 3 is not listed: it behaves as mirrored opaque
    localparam logic [MODE_BITS-1:0] MODE_FWD_KEYED      = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MIRROR_TRANSP  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MIRROR_OPAQUE  = 2'd2;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [PIXEL_BITS-1:0] key_color;
        logic [PIXEL_BITS-1:0] fill_color;
        logic [SIZE_BITS-1:0]  rect_width;
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [COORD_BITS-1:0] dest_top_row;
        logic [SIZE_BITS-1:0]  dest_pitch;
    } t_cfg;

    // Clamp pitch to the largest supported stride
    function automatic logic [SIZE_BITS-1:0] eff_pitch(input logic [SIZE_BITS-1:0] p);
        logic [SIZE_BITS-1:0] lim;
        lim = SIZE_BITS'(MAX_PITCH);
        return (p > lim) ? lim : p;
    endfunction

    // Zero width acts as one; clamp to pitch and column limits
    function automatic logic [SIZE_BITS-1:0] eff_width(input logic [SIZE_BITS-1:0] w);
        logic [SIZE_BITS-1:0] res;
        res = (w == '0) ? SIZE_BITS'(1) : w;
        if (res > SIZE_BITS'(MAX_PITCH)) begin
            res = SIZE_BITS'(MAX_PITCH);
        end
        if (res > SIZE_BITS'(COLUMN_LIMIT)) begin
            res = SIZE_BITS'(COLUMN_LIMIT);
        end
        return res;
    endfunction

endpackage

[design/ckmb_pix_if.sv]
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel carrying one source pixel per item.
// ----------------------------------------------------------------------------
interface ckmb_pix_if;
    logic                            valid;
    logic                            ready;
    logic [ckmb_pkg::PIXEL_BITS-1:0] pixel_in;
    logic                            last_in_rect;

    modport source (output valid, output pixel_in, output last_in_rect, input ready);
    modport sink   (input valid, input pixel_in, input last_in_rect, output ready);
endinterface

[design/ckmb_wr_if.sv]
// ----------------------------------------------------------------------------
// Destination write channel
// Valid/ready channel carrying one destination write per item.
// ----------------------------------------------------------------------------
interface ckmb_wr_if;
    logic                              valid;
    logic                              ready;
    logic                              write_enable;
    logic [ckmb_pkg::ADDRESS_BITS-1:0] dest_address;
    logic [ckmb_pkg::PIXEL_BITS-1:0]   pixel_out;
    logic                              row_end;
    logic                              rect_end;

    modport source (output valid, output write_enable, output dest_address,
                    output pixel_out, output row_end, output rect_end, input ready);
    modport sink   (input valid, input write_enable, input dest_address,
                    input pixel_out, input row_end, input rect_end, output ready);
endinterface

[design/color_key_mirror_blit_writer.sv]
// ----------------------------------------------------------------------------
// Color-key mirror blit writer
// Turns a row-ordered stream of source pixels into destination framebuffer
// writes, with color keying, transparency and horizontal mirroring.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the write side takes items, and returns
// one write item per pixel through the input register and then the result
// register; the write side may stall freely and the input keeps flowing while the result
// register drains. The rectangle start address (top_row - dest_y) * pitch +
// dest_x is kept precomputed in a register by the one multiplier, which sits
// on the configuration write path, so the per-pixel path is only a compare, a
// subtract and an add. Configuration is written between rectangles or while
// no item is in flight; a new rectangle starts after an item with
// last_in_rect set.
module color_key_mirror_blit_writer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ckmb_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [ckmb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    ckmb_pix_if.sink                             i_pix,
    ckmb_wr_if.source                            o_wr
);

`include "color_key_mirror_blit_writer_defines.svh"

    localparam int AB = ckmb_pkg::ADDRESS_BITS;
    localparam int SB = ckmb_pkg::SIZE_BITS;
    localparam int CB = ckmb_pkg::COORD_BITS;
    localparam int PB = ckmb_pkg::PIXEL_BITS;

    // ---------------- configuration ----------------
    ckmb_pkg::t_cfg                     r_cfg;
    ckmb_pkg::t_cfg                     n_cfg;
    logic [AB-1:0]                      r_start_base;
    logic [AB-1:0]                      n_start_base;
    logic [AB-1:0]                      w_rows;
    logic [SB-1:0]                      w_start_pitch;
    logic [ckmb_pkg::PROD_BITS-1:0]     w_prod;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (ckmb_pkg::t_cfg_index'(i_cfg_index))
                ckmb_pkg::CFG_MODE:         n_cfg.mode         = i_cfg_data[1:0];
                ckmb_pkg::CFG_KEY_COLOR:    n_cfg.key_color    = i_cfg_data[PB-1:0];
                ckmb_pkg::CFG_FILL_COLOR:   n_cfg.fill_color   = i_cfg_data[PB-1:0];
                ckmb_pkg::CFG_RECT_WIDTH:   n_cfg.rect_width   = i_cfg_data[SB-1:0];
                ckmb_pkg::CFG_DEST_X:       n_cfg.dest_x       = i_cfg_data[CB-1:0];
                ckmb_pkg::CFG_DEST_Y:       n_cfg.dest_y       = i_cfg_data[CB-1:0];
                ckmb_pkg::CFG_DEST_TOP_ROW: n_cfg.dest_top_row = i_cfg_data[CB-1:0];
                ckmb_pkg::CFG_DEST_PITCH:   n_cfg.dest_pitch   = i_cfg_data[SB-1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    // Start base follows the register values as they will be after this edge
    assign w_rows        = AB'(n_cfg.dest_top_row) - AB'(n_cfg.dest_y);
    assign w_start_pitch = ckmb_pkg::eff_pitch(n_cfg.dest_pitch);
    assign w_prod        = ckmb_pkg::PROD_BITS'(w_rows)
                         * ckmb_pkg::PROD_BITS'(w_start_pitch);
    assign n_start_base  = w_prod[AB-1:0] + AB'(n_cfg.dest_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= ckmb_pkg::MODE_FWD_KEYED;
            r_cfg.key_color    <= '0;
            r_cfg.fill_color   <= '0;
            r_cfg.rect_width   <= SB'(1);
            r_cfg.dest_x       <= '0;
            r_cfg.dest_y       <= '0;
            r_cfg.dest_top_row <= '0;
            r_cfg.dest_pitch   <= SB'(1);
            r_start_base       <= '0;
        end else begin
            r_cfg        <= n_cfg;
            r_start_base <= n_start_base;
        end
    end

    // ---------------- input register ----------------
    logic          r_in_valid;
    logic [PB-1:0] r_in_pix;
    logic          r_in_last;
    logic          r_out_valid;
    logic          w_adv;
    logic          w_in_take;

    assign w_adv       = r_in_valid && (!r_out_valid || o_wr.ready);
    assign i_pix.ready = !r_in_valid || w_adv;
    assign w_in_take   = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_in_pix  <= i_pix.pixel_in;
            r_in_last <= i_pix.last_in_rect;
        end
    end

    // ---------------- per-pixel logic ----------------
    logic [CB-1:0] r_col;
    logic [AB-1:0] r_base;
    logic          r_started;

    logic [SB-1:0] w_width;
    logic [CB-1:0] w_wm1;
    logic [CB-1:0] w_col_raw;
    logic [CB-1:0] w_col;
    logic [CB-1:0] w_offset;
    logic [AB-1:0] w_base;
    logic [AB-1:0] w_addr;
    logic          w_last_col;
    logic          w_we;
    logic [PB-1:0] w_pix_out;

    assign w_width    = ckmb_pkg::eff_width(r_cfg.rect_width);
    assign w_wm1      = CB'(w_width - SB'(1));
    assign w_base     = r_started ? r_base : r_start_base;
    assign w_col_raw  = r_started ? r_col : '0;
    // Clamp the column if the width shrank under a running rectangle
    assign w_col      = (SB'(w_col_raw) >= w_width) ? w_wm1 : w_col_raw;
    assign w_offset   = (r_cfg.mode == ckmb_pkg::MODE_FWD_KEYED) ? w_col : (w_wm1 - w_col);
    assign w_addr     = w_base + AB'(w_offset);
    assign w_last_col = (w_col == w_wm1);

    always_comb begin
        w_we      = 1'b0;
        w_pix_out = '0;
        case (r_cfg.mode)
            ckmb_pkg::MODE_FWD_KEYED: begin
                if (r_in_pix != '0) begin
                    w_we      = 1'b1;
                    w_pix_out = (r_in_pix == r_cfg.key_color) ? r_cfg.fill_color : r_in_pix;
                end
            end
            ckmb_pkg::MODE_MIRROR_TRANSP: begin
                if (r_in_pix != '0) begin
                    w_we      = 1'b1;
                    w_pix_out = r_in_pix;
                end
            end
            default: begin
                w_we      = 1'b1;
                w_pix_out = r_in_pix;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_base    <= '0;
            r_started <= 1'b0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_started <= 1'b0;
                r_col     <= '0;
                r_base    <= w_base;
            end else if (w_last_col) begin
                // advance to the next destination row
                r_started <= 1'b1;
                r_col     <= '0;
                r_base    <= w_base + AB'(ckmb_pkg::eff_pitch(r_cfg.dest_pitch));
            end else begin
                r_started <= 1'b1;
                r_col     <= w_col + CB'(1);
                r_base    <= w_base;
            end
        end
    end

    // ---------------- result register ----------------
    logic          r_we;
    logic [AB-1:0] r_addr;
    logic [PB-1:0] r_pix_out;
    logic          r_row_end;
    logic          r_rect_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_wr.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_we       <= w_we;
            r_addr     <= w_addr;
            r_pix_out  <= w_pix_out;
            r_row_end  <= w_last_col || r_in_last;
            r_rect_end <= r_in_last;
        end
    end

    assign o_wr.valid        = r_out_valid;
    assign o_wr.write_enable = r_we;
    assign o_wr.dest_address = r_addr;
    assign o_wr.pixel_out    = r_pix_out;
    assign o_wr.row_end      = r_row_end;
    assign o_wr.rect_end     = r_rect_end;

    // ---------------- assertions ----------------
    `CKMB_ASSERT_IMPLY(a_skip_zero_pix, i_clk, i_rst_n,
        r_out_valid && !r_we, r_pix_out == '0)
    `CKMB_ASSERT_IMPLY(a_rect_end_row_end, i_clk, i_rst_n,
        r_out_valid && r_rect_end, r_row_end)
    `CKMB_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n,
        w_adv && r_in_last, !r_started && (r_col == '0))
    `CKMB_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n,
        w_adv, r_out_valid)

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color-key mirror blit writer testbench
// Streams source pixels in rectangles through the writer under changing
// register settings and random back-pressure. A scoreboard predicts every
// destination write and compares it field by field against the output.
// ----------------------------------------------------------------------------
module tb_top;

    // Mode code 3 has no name in the package; it acts as mirrored opaque
    localparam logic [ckmb_pkg::MODE_BITS-1:0] MODE_OPAQUE_ALIAS = 2'd3;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic                              write_enable;
        logic [ckmb_pkg::ADDRESS_BITS-1:0] dest_address;
        logic [ckmb_pkg::PIXEL_BITS-1:0]   pixel_out;
        logic                              row_end;
        logic                              rect_end;
    } t_blit_write;

    class blit_scoreboard;
        logic [ckmb_pkg::MODE_BITS-1:0]    mode;
        logic [ckmb_pkg::PIXEL_BITS-1:0]   key_color;
        logic [ckmb_pkg::PIXEL_BITS-1:0]   fill_color;
        logic [ckmb_pkg::SIZE_BITS-1:0]    rect_width;
        logic [ckmb_pkg::COORD_BITS-1:0]   dest_x;
        logic [ckmb_pkg::COORD_BITS-1:0]   dest_y;
        logic [ckmb_pkg::COORD_BITS-1:0]   dest_top_row;
        logic [ckmb_pkg::SIZE_BITS-1:0]    dest_pitch;
        logic [ckmb_pkg::COORD_BITS-1:0]   column;
        logic [ckmb_pkg::ADDRESS_BITS-1:0] row_base;
        bit                                in_rect;
        t_blit_write                       writes_due[$];
        int unsigned                       errors;

        function new();
            mode = ckmb_pkg::MODE_FWD_KEYED;
            key_color = '0;
            fill_color = '0;
            rect_width = 11'd1;
            dest_x = '0;
            dest_y = '0;
            dest_top_row = '0;
            dest_pitch = 11'd1;
            column = '0;
            row_base = '0;
            in_rect = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(ckmb_pkg::t_cfg_index idx,
                                logic [ckmb_pkg::CFG_DATA_BITS-1:0] value);
            case (idx)
                ckmb_pkg::CFG_MODE:         mode = value[ckmb_pkg::MODE_BITS-1:0];
                ckmb_pkg::CFG_KEY_COLOR:    key_color = value[ckmb_pkg::PIXEL_BITS-1:0];
                ckmb_pkg::CFG_FILL_COLOR:   fill_color = value[ckmb_pkg::PIXEL_BITS-1:0];
                ckmb_pkg::CFG_RECT_WIDTH:   rect_width = value[ckmb_pkg::SIZE_BITS-1:0];
                ckmb_pkg::CFG_DEST_X:       dest_x = value[ckmb_pkg::COORD_BITS-1:0];
                ckmb_pkg::CFG_DEST_Y:       dest_y = value[ckmb_pkg::COORD_BITS-1:0];
                ckmb_pkg::CFG_DEST_TOP_ROW: dest_top_row = value[ckmb_pkg::COORD_BITS-1:0];
                ckmb_pkg::CFG_DEST_PITCH:   dest_pitch = value[ckmb_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [ckmb_pkg::SIZE_BITS-1:0] width_now();
            logic [ckmb_pkg::SIZE_BITS-1:0] w;
            w = (rect_width == '0) ? 11'd1 : rect_width;
            if (w > 11'd1024) begin
                w = 11'd1024;
            end
            return w;
        endfunction

        function logic [ckmb_pkg::SIZE_BITS-1:0] pitch_now();
            return (dest_pitch > 11'd1024) ? 11'd1024 : dest_pitch;
        endfunction

        function void note_pixel(logic [ckmb_pkg::PIXEL_BITS-1:0] pix, logic last);
            logic [ckmb_pkg::SIZE_BITS-1:0]    w;
            logic [ckmb_pkg::SIZE_BITS-1:0]    col;
            logic [ckmb_pkg::SIZE_BITS-1:0]    offset;
            logic [ckmb_pkg::ADDRESS_BITS-1:0] rows;
            logic [31:0]                       prod;
            t_blit_write                       exp_wr;
            w = width_now();
            // Latch the row base on the first pixel of a rectangle
            if (!in_rect) begin
                rows = {10'b0, dest_top_row} - {10'b0, dest_y};
                prod = {12'b0, rows} * {21'b0, pitch_now()};
                row_base = prod[ckmb_pkg::ADDRESS_BITS-1:0] + {10'b0, dest_x};
                column = '0;
                in_rect = 1'b1;
            end
            col = {1'b0, column};
            if (col >= w) begin
                col = w - 11'd1;
            end
            offset = (mode == ckmb_pkg::MODE_FWD_KEYED) ? col : (w - 11'd1 - col);
            exp_wr.dest_address = row_base + {9'b0, offset};
            exp_wr.write_enable = 1'b0;
            exp_wr.pixel_out = '0;
            case (mode)
                ckmb_pkg::MODE_FWD_KEYED: begin
                    if (pix != '0) begin
                        exp_wr.write_enable = 1'b1;
                        exp_wr.pixel_out = (pix == key_color) ? fill_color : pix;
                    end
                end
                ckmb_pkg::MODE_MIRROR_TRANSP: begin
                    if (pix != '0) begin
                        exp_wr.write_enable = 1'b1;
                        exp_wr.pixel_out = pix;
                    end
                end
                default: begin
                    exp_wr.write_enable = 1'b1;
                    exp_wr.pixel_out = pix;
                end
            endcase
            exp_wr.row_end = (col == w - 11'd1) || last;
            exp_wr.rect_end = last;
            if (last) begin
                in_rect = 1'b0;
                column = '0;
            end else if (col == w - 11'd1) begin
                column = '0;
                row_base = row_base + {9'b0, pitch_now()};
            end else begin
                column = col[ckmb_pkg::COORD_BITS-1:0] + 10'd1;
            end
            writes_due.push_back(exp_wr);
        endfunction

        function void check_write(t_blit_write got);
            t_blit_write exp_wr;
            if (writes_due.size() == 0) begin
                $error("write item with none expected: address %0h", got.dest_address);
                errors++;
                return;
            end
            exp_wr = writes_due.pop_front();
            if (got.write_enable !== exp_wr.write_enable) begin
                $error("write_enable: expected %0d, got %0d",
                       exp_wr.write_enable, got.write_enable);
                errors++;
            end
            if (got.dest_address !== exp_wr.dest_address) begin
                $error("dest_address: expected %0h, got %0h",
                       exp_wr.dest_address, got.dest_address);
                errors++;
            end
            if (got.pixel_out !== exp_wr.pixel_out) begin
                $error("pixel_out: expected %0h, got %0h", exp_wr.pixel_out, got.pixel_out);
                errors++;
            end
            if (got.row_end !== exp_wr.row_end) begin
                $error("row_end: expected %0d, got %0d", exp_wr.row_end, got.row_end);
                errors++;
            end
            if (got.rect_end !== exp_wr.rect_end) begin
                $error("rect_end: expected %0d, got %0d", exp_wr.rect_end, got.rect_end);
                errors++;
            end
        endfunction

        function int pending();
            return writes_due.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [ckmb_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [ckmb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    ckmb_pix_if pix_ch();
    ckmb_wr_if  wr_ch();

    blit_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    color_key_mirror_blit_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_ch),
        .o_wr        (wr_ch)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        wr_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_blit_write seen;
        if (i_rst_n === 1'b1 && wr_ch.valid === 1'b1 && wr_ch.ready === 1'b1) begin
            seen.write_enable = wr_ch.write_enable;
            seen.dest_address = wr_ch.dest_address;
            seen.pixel_out = wr_ch.pixel_out;
            seen.row_end = wr_ch.row_end;
            seen.rect_end = wr_ch.rect_end;
            sb.check_write(seen);
        end
    end

    task automatic cfg_write(input ckmb_pkg::t_cfg_index idx,
                             input logic [ckmb_pkg::CFG_DATA_BITS-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_config(input logic [ckmb_pkg::CFG_DATA_BITS-1:0] mode_v, key_v, fill_v,
                              width_v, x_v, y_v, top_v, pitch_v);
        cfg_write(ckmb_pkg::CFG_MODE, mode_v);
        cfg_write(ckmb_pkg::CFG_KEY_COLOR, key_v);
        cfg_write(ckmb_pkg::CFG_FILL_COLOR, fill_v);
        cfg_write(ckmb_pkg::CFG_RECT_WIDTH, width_v);
        cfg_write(ckmb_pkg::CFG_DEST_X, x_v);
        cfg_write(ckmb_pkg::CFG_DEST_Y, y_v);
        cfg_write(ckmb_pkg::CFG_DEST_TOP_ROW, top_v);
        cfg_write(ckmb_pkg::CFG_DEST_PITCH, pitch_v);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [ckmb_pkg::PIXEL_BITS-1:0] pix, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_in <= pix;
        pix_ch.last_in_rect <= last;
        @(posedge i_clk);
        while (pix_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        sb.note_pixel(pix, last);
    endtask

    // Hold the source until every write has come out
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [ckmb_pkg::PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(9))
            0, 1: return '0;
            2, 3: return sb.key_color;
            4: return 8'hFF;
            5: return 8'h01 << $urandom_range(7);
            default: return ckmb_pkg::PIXEL_BITS'($urandom_range(255));
        endcase
    endfunction

    task automatic random_config();
        logic [ckmb_pkg::CFG_DATA_BITS-1:0] width_v;
        logic [ckmb_pkg::CFG_DATA_BITS-1:0] pitch_v;
        case ($urandom_range(9))
            0: width_v = '0;
            1, 2: width_v = 11'($urandom_range(9, 40));
            default: width_v = 11'($urandom_range(1, 8));
        endcase
        pitch_v = ($urandom_range(4) == 0) ? 11'($urandom_range(2047))
                                           : 11'($urandom_range(1, 1024));
        set_config(11'($urandom_range(3)), 11'($urandom_range(255)),
                   11'($urandom_range(255)), width_v, 11'($urandom_range(1023)),
                   11'($urandom_range(1023)), 11'($urandom_range(1023)), pitch_v);
    endtask

    // Mostly whole rectangles; some cut short, some with random end marks
    task automatic run_rects(input int budget, inout int sent);
        int  ew;
        int  len;
        int  n;
        bit  first;
        n = 0;
        first = 1'b1;
        while (first || n < budget) begin
            ew = int'(sb.width_now());
            case ($urandom_range(9))
                0: begin
                    len = $urandom_range(1, 6);
                    repeat (len) send_pixel(rand_pixel(), 1'($urandom_range(1)));
                end
                1: begin
                    len = (ew > 40) ? $urandom_range(1, 12) : $urandom_range(1, ew * 2);
                    for (int k = 1; k <= len; k++) send_pixel(rand_pixel(), k == len);
                end
                default: begin
                    if (ew > 40) begin
                        len = first ? ew : $urandom_range(1, 12);
                    end else begin
                        len = ew * $urandom_range(1, 4);
                    end
                    for (int k = 1; k <= len; k++) send_pixel(rand_pixel(), k == len);
                end
            endcase
            n += len;
            first = 1'b0;
        end
        sent += n;
    endtask

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int sent;
        int ph;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= ckmb_pkg::CFG_MODE;
        i_cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_in <= '0;
        pix_ch.last_in_rect <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Keyed forward copy, left edge at column 1023, pitch above the limit
        set_config(11'(ckmb_pkg::MODE_FWD_KEYED), 11'h5A, 11'hA5, 11'd3, 11'd1023, 11'd2,
                   11'd1023, 11'd2047);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h5A, 1'b1);
        drain();

        // Mirrored transparent, destination row above the top, zero pitch
        set_config(11'(ckmb_pkg::MODE_MIRROR_TRANSP), 11'h00, 11'hFF, 11'd4, 11'd0, 11'd1000,
                   11'd5, 11'd0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h11, 1'b0);
        send_pixel(8'h22, 1'b0);
        drain();
        // Change mode and width inside the rectangle; the row base stays
        cfg_write(ckmb_pkg::CFG_MODE, 11'(ckmb_pkg::MODE_MIRROR_OPAQUE));
        cfg_write(ckmb_pkg::CFG_RECT_WIDTH, 11'd0);
        i_cfg_we <= 1'b0;
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h33, 1'b1);
        drain();

        // Code 3 with width over the limit, early end mid-row
        set_config(11'(MODE_OPAQUE_ALIAS), 11'hFF, 11'h00, 11'd2047, 11'd1023, 11'd0, 11'd1023,
                   11'd1024);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h01, 1'b1);
        drain();

        // Key of zero: zero pixels still skipped
        set_config(11'(ckmb_pkg::MODE_FWD_KEYED), 11'h00, 11'hFF, 11'd1, 11'd0, 11'd0, 11'd0,
                   11'd1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        drain();

        sent = 0;
        ph = 0;
        while (sent < RANDOM_ITEMS || ph < 4) begin
            case (ph)
                0: set_config(11'(ckmb_pkg::MODE_FWD_KEYED), 11'h00, 11'h00, 11'd0, 11'd0,
                              11'd0, 11'd0, 11'd0);
                1: set_config(11'(MODE_OPAQUE_ALIAS), 11'hFF, 11'hFF, 11'd2047, 11'd1023,
                              11'd1023, 11'd1023, 11'd2047);
                default: random_config();
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            run_rects((ph == 1) ? 40 : 60, sent);
            drain();
            ph++;
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

[color_key_mirror_blit_writer.f]
+incdir+design
design/ckmb_pkg.sv
design/ckmb_pix_if.sv
design/ckmb_wr_if.sv
design/color_key_mirror_blit_writer.sv
tb/sv/tb_top.sv
